/* sv/wavp_pkg.sv */
// types and constants shared by the wav header parser and pcm expander
`timescale 1ns / 1ps

package wavp_pkg;

    // four-character chunk tags, little-endian as they sit in the file
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_JUNK = 32'h4b4e_554a;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // smallest legal file and smallest legal fmt chunk body
    localparam logic [31:0] MIN_FILE_BYTES = 32'd44;
    localparam logic [31:0] MIN_FMT_BYTES  = 32'd16;

    // pcm format tag and the fixed skip over byte rate and block align
    localparam logic [31:0] FMT_TAG_PCM = 32'd1;
    localparam logic [31:0] FMT_GAP_BYTES = 32'd6;

    // 8-bit pcm is offset binary: flip the top bit to get two's complement
    localparam logic [7:0] PCM8_OFFSET = 8'h80;

    // parse phases, one-hot
    typedef enum logic [20:0] {
        PH_RIFF_TAG   = 21'h000001,
        PH_RIFF_SIZE  = 21'h000002,
        PH_WAVE_TAG   = 21'h000004,
        PH_FIRST_TAG  = 21'h000008,
        PH_JUNK_SIZE  = 21'h000010,
        PH_JUNK_SKIP  = 21'h000020,
        PH_FMT_TAG    = 21'h000040,
        PH_FMT_SIZE   = 21'h000080,
        PH_COMP       = 21'h000100,
        PH_CHANS      = 21'h000200,
        PH_RATE       = 21'h000400,
        PH_SKIP6      = 21'h000800,
        PH_BITS       = 21'h001000,
        PH_FMT_SKIP   = 21'h002000,
        PH_CHUNK_TAG  = 21'h004000,
        PH_CHUNK_SIZE = 21'h008000,
        PH_CHUNK_SKIP = 21'h010000,
        PH_DATA_SIZE  = 21'h020000,
        PH_DATA       = 21'h040000,
        PH_DONE       = 21'h080000,
        PH_MUTED      = 21'h100000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_FORMAT = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2
    } result_kind_t;

    typedef enum logic [3:0] {
        ERR_TOO_SMALL   = 4'd0,
        ERR_RIFF        = 4'd1,
        ERR_WAVE        = 4'd2,
        ERR_JUNK        = 4'd3,
        ERR_FMT_TAG     = 4'd4,
        ERR_FMT_SIZE    = 4'd5,
        ERR_COMPRESSION = 4'd6,
        ERR_CHANNELS    = 4'd7,
        ERR_RATE        = 4'd8,
        ERR_BITS        = 4'd9,
        ERR_TRUNCATED   = 4'd10,
        ERR_CHUNK_SIZE  = 4'd11,
        ERR_DATA_SIZE   = 4'd12
    } err_code_t;

    // one input item: a file byte and its end-of-file mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } item_t;

    // one result item
    typedef struct packed {
        result_kind_t       result_kind;
        logic signed [15:0] sample_value;
        logic               channel_index;
        logic [31:0]        rate_hz;
        logic [1:0]         channels;
        logic [1:0]         sample_bytes;
        logic [31:0]        frames;
        err_code_t          error_code;
        logic               final_result;
    } result_t;

    localparam int unsigned OUT_TDATA_W = 96;

endpackage

/* sv/wav_header_parse_pcm_expand.sv */
// top level of the wav header parser and pcm sample expander
//
// Bytes of a WAV file enter on the slave stream one per item, in file
// order, with tlast on the final byte. Before each file, write its total
// byte length through cfg_wr_en / cfg_wr_data while the block is idle.
// Results leave on the master stream: tuser gives the kind (format,
// sample, error), tdata the fields, tlast marks the last sample or an error.
// A stream yields one format item after the data chunk header, then one
// signed 16-bit sample per channel value; the first failure gives one error
// item and the rest of the file up to tlast is dropped.
// Throughput is one byte per clock while the receiver does not stall. A
// byte is registered in the input register and its result, if any, is
// loaded into the result register when the parser steps on that byte.
// Parsing is a single pass through the phase machine between those two
// registers. When the receiver stalls with a result held, the input
// register still takes one more byte; further bytes wait. Reset clears
// the phase machine, the valid flags of both registers and the file length.
`timescale 1ns / 1ps

module wav_header_parse_pcm_expand (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // end_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sample_value[15:0], channel_index[16], rate_hz[48:17], channels[50:49],
    // sample_bytes[52:51], frames[84:53], error_code[88:85], zero[95:89]
    output logic [95:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // result_kind
    output logic        m_axis_tlast    // final_result
);
    import wavp_pkg::*;

    logic [31:0] file_length_reg;
    item_t       s_item;
    item_t       item;
    logic        item_valid;
    logic        out_space;
    logic        step;
    logic        res_valid;
    result_t     res;

    // file length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= 32'd0;
        end
        else if (cfg_wr_en)
        begin
            file_length_reg <= cfg_wr_data;
        end
    end

    assign s_item.data_byte   = s_axis_tdata;
    assign s_item.end_of_file = s_axis_tlast;

    // an item is processed when the result register can take its output
    assign step = item_valid && out_space;

    wavp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (step)
    );

    wavp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (item),
        .file_length (file_length_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    wavp_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (step && res_valid),
        .res           (res),
        .space         (out_space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* sv/wavp_in_stage.sv */
// input register of the byte stream
`timescale 1ns / 1ps

module wavp_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_valid,
    output logic            s_ready,
    input  wavp_pkg::item_t s_item,
    output logic            item_valid,
    output wavp_pkg::item_t item,
    input  logic            item_take
);
    import wavp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // room when empty or when the held item moves on this cycle
    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= s_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

/* sv/wavp_parser.sv */
// header parse state machine and pcm sample expansion, one byte per step
`timescale 1ns / 1ps

module wavp_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  wavp_pkg::item_t   item,
    input  logic [31:0]       file_length,
    output logic              res_valid,
    output wavp_pkg::result_t res
);
    import wavp_pkg::*;

    phase_t      phase_reg,       phase_next;
    logic [31:0] field_shift_reg, field_shift_next;
    logic [1:0]  field_count_reg, field_count_next;
    logic [31:0] byte_pos_reg,    byte_pos_next;
    logic [31:0] skip_rem_reg,    skip_rem_next;
    logic [31:0] fmt_extra_reg,   fmt_extra_next;
    logic [1:0]  held_chan_reg,   held_chan_next;
    logic [31:0] held_rate_reg,   held_rate_next;
    logic [1:0]  held_sbytes_reg, held_sbytes_next;
    logic [31:0] data_rem_reg,    data_rem_next;
    logic [7:0]  low_byte_reg,    low_byte_next;
    logic        chan_tog_reg,    chan_tog_next;

    logic [7:0]  b;
    logic        active;
    logic [31:0] pos;
    logic [31:0] assembled;
    logic [1:0]  count_inc;
    logic        take4_done;
    logic        take2_done;
    logic [32:0] padded;
    logic [33:0] over_add;
    logic        beyond;
    logic [31:0] skip_dec;
    logic [31:0] data_dec;
    logic [3:0]  frame_bytes;
    logic        frame_bad;
    logic        frame_misaligned;
    logic [31:0] frame_count;
    logic        fail;
    err_code_t   fail_code;
    logic        emit_sample;
    logic [15:0] sample;

    assign b      = item.data_byte;
    assign active = (phase_reg != PH_DONE) && (phase_reg != PH_MUTED);
    assign pos    = byte_pos_reg + 32'd1;

    // little-endian field assembly including the current byte
    always_comb
    begin
        if (field_count_reg == 2'd0)
        begin
            assembled = {24'd0, b};
        end
        else
        begin
            assembled = field_shift_reg | ({24'd0, b} << {field_count_reg, 3'b000});
        end
        count_inc  = field_count_reg + 2'd1;
        take4_done = (field_count_reg == 2'd3);
        take2_done = (field_count_reg != 2'd0);
        padded     = {1'b0, assembled} + {32'd0, assembled[0]};
    end

    // one shared bound check: position after this byte plus what follows
    always_comb
    begin
        unique case (phase_reg)
            PH_JUNK_SIZE, PH_CHUNK_SIZE: over_add = 34'd4 + {1'b0, padded};
            PH_FMT_SIZE:                 over_add = {1'b0, padded};
            PH_DATA_SIZE:                over_add = {2'b00, assembled};
            default:                     over_add = 34'd4;
        endcase
        beyond = ({2'b00, pos} + over_add) > {2'b00, file_length};
    end

    // down-counters
    assign skip_dec = (skip_rem_reg == 32'd0) ? 32'd0 : skip_rem_reg - 32'd1;
    assign data_dec = (data_rem_reg == 32'd0) ? 32'd0 : data_rem_reg - 32'd1;

    // frame size is 1, 2 or 4 bytes, so the frame count is a shift
    always_comb
    begin
        frame_bytes = {2'b00, held_chan_reg} * {2'b00, held_sbytes_reg};
        frame_bad        = 1'b0;
        frame_misaligned = 1'b0;
        frame_count      = assembled;
        case (frame_bytes)
            4'd1:
            begin
                frame_count = assembled;
            end
            4'd2:
            begin
                frame_misaligned = assembled[0];
                frame_count      = {1'b0, assembled[31:1]};
            end
            4'd4:
            begin
                frame_misaligned = (assembled[1:0] != 2'b00);
                frame_count      = {2'b00, assembled[31:2]};
            end
            default:
            begin
                frame_bad = 1'b1;
            end
        endcase
    end

    // next state and result
    always_comb
    begin
        phase_next       = phase_reg;
        field_shift_next = field_shift_reg;
        field_count_next = field_count_reg;
        byte_pos_next    = active ? pos : byte_pos_reg;
        skip_rem_next    = skip_rem_reg;
        fmt_extra_next   = fmt_extra_reg;
        held_chan_next   = held_chan_reg;
        held_rate_next   = held_rate_reg;
        held_sbytes_next = held_sbytes_reg;
        data_rem_next    = data_rem_reg;
        low_byte_next    = low_byte_reg;
        chan_tog_next    = chan_tog_reg;
        fail             = 1'b0;
        fail_code        = ERR_TOO_SMALL;
        emit_sample      = 1'b0;
        sample           = 16'd0;
        res_valid        = 1'b0;
        res              = '0;

        unique case (phase_reg)
            PH_RIFF_TAG:
            begin
                if (field_count_reg == 2'd0 && file_length < MIN_FILE_BYTES)
                begin
                    fail      = 1'b1;
                    fail_code = ERR_TOO_SMALL;
                end
                else
                begin
                    field_shift_next = assembled;
                    field_count_next = take4_done ? 2'd0 : count_inc;
                    if (take4_done)
                    begin
                        if (assembled != TAG_RIFF)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_RIFF;
                        end
                        else
                        begin
                            phase_next = PH_RIFF_SIZE;
                        end
                    end
                end
            end
            PH_RIFF_SIZE:
            begin
                field_shift_next = assembled;
                field_count_next = take4_done ? 2'd0 : count_inc;
                if (take4_done)
                begin
                    phase_next = PH_WAVE_TAG;
                end
            end
            PH_WAVE_TAG:
            begin
                field_shift_next = assembled;
                field_count_next = take4_done ? 2'd0 : count_inc;
                if (take4_done)
                begin
                    if (assembled != TAG_WAVE)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_WAVE;
                    end
                    else
                    begin
                        phase_next = PH_FIRST_TAG;
                    end
                end
            end
            PH_FIRST_TAG:
            begin
                field_shift_next = assembled;
                field_count_next = take4_done ? 2'd0 : count_inc;
                if (take4_done)
                begin
                    if (assembled == TAG_JUNK)
                    begin
                        if (beyond)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_JUNK;
                        end
                        else
                        begin
                            phase_next = PH_JUNK_SIZE;
                        end
                    end
                    else if (assembled == TAG_FMT)
                    begin
                        phase_next = PH_FMT_SIZE;
                    end
                    else
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_FMT_TAG;
                    end
                end
            end
            PH_JUNK_SIZE:
            begin
                field_shift_next = assembled;
                field_count_next = take4_done ? 2'd0 : count_inc;
                if (take4_done)
                begin
                    if (beyond)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_JUNK;
                    end
                    else if (padded == 33'd0)
                    begin
                        phase_next = PH_FMT_TAG;
                    end
                    else
                    begin
                        skip_rem_next = padded[31:0];
                        phase_next    = PH_JUNK_SKIP;
                    end
                end
            end
            PH_JUNK_SKIP:
            begin
                skip_rem_next = skip_dec;
                if (skip_dec == 32'd0)
                begin
                    phase_next = PH_FMT_TAG;
                end
            end
            PH_FMT_TAG:
            begin
                field_shift_next = assembled;
                field_count_next = take4_done ? 2'd0 : count_inc;
                if (take4_done)
                begin
                    if (assembled != TAG_FMT)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_FMT_TAG;
                    end
                    else
                    begin
                        phase_next = PH_FMT_SIZE;
                    end
                end
            end
            PH_FMT_SIZE:
            begin
                field_shift_next = assembled;
                field_count_next = take4_done ? 2'd0 : count_inc;
                if (take4_done)
                begin
                    if (assembled < MIN_FMT_BYTES || beyond)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_FMT_SIZE;
                    end
                    else
                    begin
                        fmt_extra_next = assembled - MIN_FMT_BYTES + {31'd0, assembled[0]};
                        phase_next     = PH_COMP;
                    end
                end
            end
            PH_COMP:
            begin
                field_shift_next = assembled;
                field_count_next = take2_done ? 2'd0 : count_inc;
                if (take2_done)
                begin
                    if (assembled != FMT_TAG_PCM)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_COMPRESSION;
                    end
                    else
                    begin
                        phase_next = PH_CHANS;
                    end
                end
            end
            PH_CHANS:
            begin
                field_shift_next = assembled;
                field_count_next = take2_done ? 2'd0 : count_inc;
                if (take2_done)
                begin
                    if (assembled != 32'd1 && assembled != 32'd2)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_CHANNELS;
                    end
                    else
                    begin
                        held_chan_next = assembled[1:0];
                        phase_next     = PH_RATE;
                    end
                end
            end
            PH_RATE:
            begin
                field_shift_next = assembled;
                field_count_next = take4_done ? 2'd0 : count_inc;
                if (take4_done)
                begin
                    if (assembled == 32'd0)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_RATE;
                    end
                    else
                    begin
                        held_rate_next = assembled;
                        skip_rem_next  = FMT_GAP_BYTES;
                        phase_next     = PH_SKIP6;
                    end
                end
            end
            PH_SKIP6:
            begin
                skip_rem_next = skip_dec;
                if (skip_dec == 32'd0)
                begin
                    phase_next = PH_BITS;
                end
            end
            PH_BITS:
            begin
                field_shift_next = assembled;
                field_count_next = take2_done ? 2'd0 : count_inc;
                if (take2_done)
                begin
                    if (assembled != 32'd8 && assembled != 32'd16)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_BITS;
                    end
                    else
                    begin
                        // 8 bits gives 1 byte, 16 bits gives 2
                        held_sbytes_next = assembled[4:3];
                        if (fmt_extra_reg != 32'd0)
                        begin
                            skip_rem_next = fmt_extra_reg;
                            phase_next    = PH_FMT_SKIP;
                        end
                        else if (beyond)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_TRUNCATED;
                        end
                        else
                        begin
                            phase_next = PH_CHUNK_TAG;
                        end
                    end
                end
            end
            PH_FMT_SKIP:
            begin
                skip_rem_next = skip_dec;
                if (skip_dec == 32'd0)
                begin
                    if (beyond)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNCATED;
                    end
                    else
                    begin
                        phase_next = PH_CHUNK_TAG;
                    end
                end
            end
            PH_CHUNK_TAG:
            begin
                field_shift_next = assembled;
                field_count_next = take4_done ? 2'd0 : count_inc;
                if (take4_done)
                begin
                    if (beyond)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNCATED;
                    end
                    else if (assembled == TAG_DATA)
                    begin
                        phase_next = PH_DATA_SIZE;
                    end
                    else
                    begin
                        phase_next = PH_CHUNK_SIZE;
                    end
                end
            end
            PH_CHUNK_SIZE:
            begin
                field_shift_next = assembled;
                field_count_next = take4_done ? 2'd0 : count_inc;
                if (take4_done)
                begin
                    if (beyond)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_CHUNK_SIZE;
                    end
                    else if (padded == 33'd0)
                    begin
                        phase_next = PH_CHUNK_TAG;
                    end
                    else
                    begin
                        skip_rem_next = padded[31:0];
                        phase_next    = PH_CHUNK_SKIP;
                    end
                end
            end
            PH_CHUNK_SKIP:
            begin
                skip_rem_next = skip_dec;
                if (skip_dec == 32'd0)
                begin
                    phase_next = PH_CHUNK_TAG;
                end
            end
            PH_DATA_SIZE:
            begin
                field_shift_next = assembled;
                field_count_next = take4_done ? 2'd0 : count_inc;
                if (take4_done)
                begin
                    if (frame_bad || assembled == 32'd0 || frame_misaligned || beyond)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_DATA_SIZE;
                    end
                    else
                    begin
                        data_rem_next        = assembled;
                        chan_tog_next        = 1'b0;
                        phase_next           = PH_DATA;
                        res_valid            = 1'b1;
                        res.result_kind      = KIND_FORMAT;
                        res.rate_hz          = held_rate_reg;
                        res.channels         = held_chan_reg;
                        res.sample_bytes     = held_sbytes_reg;
                        res.frames           = frame_count;
                    end
                end
            end
            PH_DATA:
            begin
                data_rem_next = data_dec;
                if (held_sbytes_reg == 2'd1)
                begin
                    sample      = {b ^ PCM8_OFFSET, 8'h00};
                    emit_sample = 1'b1;
                end
                else if (field_count_reg == 2'd0)
                begin
                    low_byte_next    = b;
                    field_count_next = 2'd1;
                end
                else
                begin
                    field_count_next = 2'd0;
                    sample           = {b, low_byte_reg};
                    emit_sample      = 1'b1;
                end
                if (emit_sample)
                begin
                    res_valid         = 1'b1;
                    res.result_kind   = KIND_SAMPLE;
                    res.sample_value  = sample;
                    res.channel_index = chan_tog_reg;
                    res.final_result  = (data_dec == 32'd0);
                    if (held_chan_reg == 2'd2)
                    begin
                        chan_tog_next = !chan_tog_reg;
                    end
                    if (data_dec == 32'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_DONE, PH_MUTED:
            begin
                // bytes ignored until end of file
            end
            default:
            begin
                fail      = 1'b1;
                fail_code = ERR_TRUNCATED;
            end
        endcase

        // first failure mutes the stream
        if (fail)
        begin
            phase_next       = PH_MUTED;
            res_valid        = 1'b1;
            res              = '0;
            res.result_kind  = KIND_ERROR;
            res.error_code   = fail_code;
            res.final_result = 1'b1;
        end

        // end of file: close an unfinished stream with an error, then restart
        if (item.end_of_file)
        begin
            if (active && !(res_valid && res.final_result))
            begin
                res_valid        = 1'b1;
                res              = '0;
                res.result_kind  = KIND_ERROR;
                res.error_code   = (phase_next == PH_DATA) ? ERR_DATA_SIZE : ERR_TRUNCATED;
                res.final_result = 1'b1;
            end
            phase_next       = PH_RIFF_TAG;
            field_shift_next = 32'd0;
            field_count_next = 2'd0;
            byte_pos_next    = 32'd0;
            skip_rem_next    = 32'd0;
            fmt_extra_next   = 32'd0;
            held_chan_next   = 2'd0;
            held_rate_next   = 32'd0;
            held_sbytes_next = 2'd0;
            data_rem_next    = 32'd0;
            low_byte_next    = 8'd0;
            chan_tog_next    = 1'b0;
        end
    end

    // parse state, advanced once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_RIFF_TAG;
            field_shift_reg <= 32'd0;
            field_count_reg <= 2'd0;
            byte_pos_reg    <= 32'd0;
            skip_rem_reg    <= 32'd0;
            fmt_extra_reg   <= 32'd0;
            held_chan_reg   <= 2'd0;
            held_rate_reg   <= 32'd0;
            held_sbytes_reg <= 2'd0;
            data_rem_reg    <= 32'd0;
            low_byte_reg    <= 8'd0;
            chan_tog_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            field_shift_reg <= field_shift_next;
            field_count_reg <= field_count_next;
            byte_pos_reg    <= byte_pos_next;
            skip_rem_reg    <= skip_rem_next;
            fmt_extra_reg   <= fmt_extra_next;
            held_chan_reg   <= held_chan_next;
            held_rate_reg   <= held_rate_next;
            held_sbytes_reg <= held_sbytes_next;
            data_rem_reg    <= data_rem_next;
            low_byte_reg    <= low_byte_next;
            chan_tog_reg    <= chan_tog_next;
        end
    end

endmodule

/* sv/wavp_out_stage.sv */
// result register and packing onto the master stream
`timescale 1ns / 1ps

module wavp_out_stage (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  wavp_pkg::result_t                  res,
    output logic                               space,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [wavp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [1:0]                         m_axis_tuser,
    output logic                               m_axis_tlast
);
    import wavp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // free when empty or being taken this cycle
    assign space = !valid_reg || m_axis_tready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    // stream packing
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = res_reg.result_kind;
    assign m_axis_tlast  = res_reg.final_result;
    assign m_axis_tdata  = {7'd0,
                            res_reg.error_code,
                            res_reg.frames,
                            res_reg.sample_bytes,
                            res_reg.channels,
                            res_reg.rate_hz,
                            res_reg.channel_index,
                            res_reg.sample_value};

endmodule

/* sim/wav_header_parse_pcm_expand_test.sv */
// self-checking testbench for the wav header parser and pcm sample expander
`timescale 1ns / 1ps

module wav_header_parse_pcm_expand_test;
    import wavp_pkg::*;

    // tag of an unknown chunk placed between fmt and data
    localparam logic [31:0] TAG_LIST = 32'h5453_494c;
    localparam logic [15:0] FMT_PCM = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;
    localparam int TIMEOUT_NS = 20_000_000;

    // parser state mirror plus the queue of results still to arrive
    class wav_result_board;
        logic [31:0] file_len;
        phase_t      phase;
        logic [31:0] shift_reg;
        logic [1:0]  field_cnt;
        logic [31:0] pos_cnt;
        logic [31:0] skip_cnt;
        logic [31:0] fmt_extra;
        logic [31:0] data_left;
        logic [31:0] rate_held;
        logic [1:0]  chans_held;
        logic [1:0]  bytes_held;
        logic [7:0]  low_hold;
        logic        chan_sel;
        result_t     outcome;
        bit          produced;
        result_t     pending_results[$];
        int unsigned bytes_seen;
        int unsigned files_seen;
        int unsigned formats_seen;
        int unsigned samples_seen;
        int unsigned errors_seen;
        int unsigned fail_count;
        logic [15:0] codes_seen;

        function void restart();
            phase = PH_RIFF_TAG;
            shift_reg = '0;
            field_cnt = '0;
            pos_cnt = '0;
            skip_cnt = '0;
            fmt_extra = '0;
            data_left = '0;
            rate_held = '0;
            chans_held = '0;
            bytes_held = '0;
            low_hold = '0;
            chan_sel = 1'b0;
        endfunction

        function void clear_all();
            restart();
            file_len = '0;
            pending_results.delete();
            bytes_seen = 0;
            files_seen = 0;
            formats_seen = 0;
            samples_seen = 0;
            errors_seen = 0;
            fail_count = 0;
            codes_seen = '0;
        endfunction

        // gathers a little-endian field, true once all its bytes are in
        function bit take(logic [7:0] b, int width);
            int n;
            n = field_cnt;
            if (n == 0)
                shift_reg = {24'd0, b};
            else
                shift_reg = shift_reg | ({24'd0, b} << (8 * n));
            n++;
            if (n >= width)
            begin
                field_cnt = '0;
                return 1'b1;
            end
            field_cnt = 2'(n);
            return 1'b0;
        endfunction

        function void reject(err_code_t code);
            outcome = '0;
            outcome.result_kind = KIND_ERROR;
            outcome.error_code = code;
            outcome.final_result = 1'b1;
            produced = 1'b1;
            phase = PH_MUTED;
        endfunction

        // the next chunk header must still fit inside the file
        function void open_chunk_tag(longint unsigned pos, longint unsigned fl);
            if (pos + 4 > fl)
                reject(ERR_TRUNCATED);
            else
                phase = PH_CHUNK_TAG;
        endfunction

        // works out the result, if any, that one accepted byte causes
        function void absorb_byte(logic [7:0] b, logic eof);
            longint unsigned pos;
            longint unsigned fl;
            longint unsigned padded;
            logic [31:0]     frame_bytes;
            logic [15:0]     pcm_word;
            bit              emit;
            err_code_t       late_code;
            outcome = '0;
            produced = 1'b0;
            emit = 1'b0;
            pcm_word = '0;
            bytes_seen++;
            if (eof)
                files_seen++;
            // muted or finished: drop everything up to the end of the file
            if (phase == PH_DONE || phase == PH_MUTED)
            begin
                if (eof)
                    restart();
                return;
            end
            pos_cnt++;
            pos = {32'd0, pos_cnt};
            fl = {32'd0, file_len};
            case (phase)
                PH_RIFF_TAG:
                    if (field_cnt == 0 && fl < MIN_FILE_BYTES)
                        reject(ERR_TOO_SMALL);
                    else if (take(b, 4))
                    begin
                        if (shift_reg != TAG_RIFF)
                            reject(ERR_RIFF);
                        else
                            phase = PH_RIFF_SIZE;
                    end
                PH_RIFF_SIZE:
                    if (take(b, 4))
                        phase = PH_WAVE_TAG;
                PH_WAVE_TAG:
                    if (take(b, 4))
                    begin
                        if (shift_reg != TAG_WAVE)
                            reject(ERR_WAVE);
                        else
                            phase = PH_FIRST_TAG;
                    end
                PH_FIRST_TAG:
                    if (take(b, 4))
                    begin
                        if (shift_reg == TAG_JUNK)
                        begin
                            if (pos + 4 > fl)
                                reject(ERR_JUNK);
                            else
                                phase = PH_JUNK_SIZE;
                        end
                        else if (shift_reg == TAG_FMT)
                            phase = PH_FMT_SIZE;
                        else
                            reject(ERR_FMT_TAG);
                    end
                PH_JUNK_SIZE:
                    if (take(b, 4))
                    begin
                        padded = {32'd0, shift_reg} + shift_reg[0];
                        if (pos + 4 + padded > fl)
                            reject(ERR_JUNK);
                        else if (padded == 0)
                            phase = PH_FMT_TAG;
                        else
                        begin
                            skip_cnt = padded[31:0];
                            phase = PH_JUNK_SKIP;
                        end
                    end
                PH_JUNK_SKIP:
                begin
                    if (skip_cnt != 0)
                        skip_cnt--;
                    if (skip_cnt == 0)
                        phase = PH_FMT_TAG;
                end
                PH_FMT_TAG:
                    if (take(b, 4))
                    begin
                        if (shift_reg != TAG_FMT)
                            reject(ERR_FMT_TAG);
                        else
                            phase = PH_FMT_SIZE;
                    end
                PH_FMT_SIZE:
                    if (take(b, 4))
                    begin
                        padded = {32'd0, shift_reg} + shift_reg[0];
                        if (shift_reg < MIN_FMT_BYTES || pos + padded > fl)
                            reject(ERR_FMT_SIZE);
                        else
                        begin
                            fmt_extra = shift_reg - MIN_FMT_BYTES + shift_reg[0];
                            phase = PH_COMP;
                        end
                    end
                PH_COMP:
                    if (take(b, 2))
                    begin
                        if (shift_reg != FMT_TAG_PCM)
                            reject(ERR_COMPRESSION);
                        else
                            phase = PH_CHANS;
                    end
                PH_CHANS:
                    if (take(b, 2))
                    begin
                        if (shift_reg != 1 && shift_reg != 2)
                            reject(ERR_CHANNELS);
                        else
                        begin
                            chans_held = shift_reg[1:0];
                            phase = PH_RATE;
                        end
                    end
                PH_RATE:
                    if (take(b, 4))
                    begin
                        if (shift_reg == 0)
                            reject(ERR_RATE);
                        else
                        begin
                            rate_held = shift_reg;
                            skip_cnt = FMT_GAP_BYTES;
                            phase = PH_SKIP6;
                        end
                    end
                PH_SKIP6:
                begin
                    if (skip_cnt != 0)
                        skip_cnt--;
                    if (skip_cnt == 0)
                        phase = PH_BITS;
                end
                PH_BITS:
                    if (take(b, 2))
                    begin
                        if (shift_reg != 8 && shift_reg != 16)
                            reject(ERR_BITS);
                        else
                        begin
                            bytes_held = 2'(shift_reg / 8);
                            if (fmt_extra != 0)
                            begin
                                skip_cnt = fmt_extra;
                                phase = PH_FMT_SKIP;
                            end
                            else
                                open_chunk_tag(pos, fl);
                        end
                    end
                PH_FMT_SKIP:
                begin
                    if (skip_cnt != 0)
                        skip_cnt--;
                    if (skip_cnt == 0)
                        open_chunk_tag(pos, fl);
                end
                PH_CHUNK_TAG:
                    if (take(b, 4))
                    begin
                        if (pos + 4 > fl)
                            reject(ERR_TRUNCATED);
                        else if (shift_reg == TAG_DATA)
                            phase = PH_DATA_SIZE;
                        else
                            phase = PH_CHUNK_SIZE;
                    end
                PH_CHUNK_SIZE:
                    if (take(b, 4))
                    begin
                        padded = {32'd0, shift_reg} + shift_reg[0];
                        if (pos + 4 + padded > fl)
                            reject(ERR_CHUNK_SIZE);
                        else if (padded == 0)
                            phase = PH_CHUNK_TAG;
                        else
                        begin
                            skip_cnt = padded[31:0];
                            phase = PH_CHUNK_SKIP;
                        end
                    end
                PH_CHUNK_SKIP:
                begin
                    if (skip_cnt != 0)
                        skip_cnt--;
                    if (skip_cnt == 0)
                        phase = PH_CHUNK_TAG;
                end
                PH_DATA_SIZE:
                    if (take(b, 4))
                    begin
                        frame_bytes = {30'd0, chans_held} * {30'd0, bytes_held};
                        if (frame_bytes == 0 || shift_reg == 0 ||
                            shift_reg % frame_bytes != 0 || pos + shift_reg > fl)
                            reject(ERR_DATA_SIZE);
                        else
                        begin
                            data_left = shift_reg;
                            chan_sel = 1'b0;
                            phase = PH_DATA;
                            outcome.result_kind = KIND_FORMAT;
                            outcome.rate_hz = rate_held;
                            outcome.channels = chans_held;
                            outcome.sample_bytes = bytes_held;
                            outcome.frames = shift_reg / frame_bytes;
                            produced = 1'b1;
                        end
                    end
                PH_DATA:
                begin
                    if (data_left != 0)
                        data_left--;
                    // 8-bit is offset binary, 16-bit arrives low byte first
                    if (bytes_held == 1)
                    begin
                        pcm_word = {b ^ PCM8_OFFSET, 8'h00};
                        emit = 1'b1;
                    end
                    else if (field_cnt == 0)
                    begin
                        low_hold = b;
                        field_cnt = 2'd1;
                    end
                    else
                    begin
                        field_cnt = '0;
                        pcm_word = {b, low_hold};
                        emit = 1'b1;
                    end
                    if (emit)
                    begin
                        outcome.result_kind = KIND_SAMPLE;
                        outcome.sample_value = pcm_word;
                        outcome.channel_index = chan_sel;
                        outcome.final_result = (data_left == 0);
                        if (chans_held == 2)
                            chan_sel = ~chan_sel;
                        if (data_left == 0)
                            phase = PH_DONE;
                        produced = 1'b1;
                    end
                end
                default:
                    reject(ERR_TRUNCATED);
            endcase
            // end of file before the last sample turns into an error
            if (eof)
            begin
                if (!(produced && outcome.final_result))
                begin
                    late_code = (phase == PH_DATA) ? ERR_DATA_SIZE : ERR_TRUNCATED;
                    reject(late_code);
                end
                restart();
            end
            if (produced)
            begin
                pending_results.push_back(outcome);
                case (outcome.result_kind)
                    KIND_FORMAT: formats_seen++;
                    KIND_SAMPLE: samples_seen++;
                    default:
                    begin
                        errors_seen++;
                        codes_seen[outcome.error_code] = 1'b1;
                    end
                endcase
            end
        endfunction

        function void check_field(string name, logic [31:0] want_v, logic [31:0] seen_v);
            if (want_v !== seen_v)
            begin
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want_v, seen_v);
                fail_count++;
            end
        endfunction

        // compares an accepted result with the oldest one still owed
        function void match_result(result_t seen);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual kind %0d code %0d",
                         $time, seen.result_kind, seen.error_code);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            check_field("result_kind", want.result_kind, seen.result_kind);
            check_field("sample_value", $unsigned(want.sample_value),
                        $unsigned(seen.sample_value));
            check_field("channel_index", want.channel_index, seen.channel_index);
            check_field("rate_hz", want.rate_hz, seen.rate_hz);
            check_field("channels", want.channels, seen.channels);
            check_field("sample_bytes", want.sample_bytes, seen.sample_bytes);
            check_field("frames", want.frames, seen.frames);
            check_field("error_code", want.error_code, seen.error_code);
            check_field("final_result", want.final_result, seen.final_result);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    wav_result_board board = new();
    result_t     seen_result;
    logic [7:0]  wav_bytes[$];
    logic [7:0]  pcm_extremes[4] = '{8'h00, 8'h80, 8'hFF, 8'h7F};
    bit          extreme_fill = 1'b0;
    int          data_tag_at;
    int          other_size_at;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          stall_left = 0;

    wav_header_parse_pcm_expand u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver back-pressure: free flow, random, sparse and long stalls
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (stall_left % 16 == 0);
        endcase
    end

    // watch both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.absorb_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_result.result_kind = result_kind_t'(m_axis_tuser);
                seen_result.sample_value = m_axis_tdata[15:0];
                seen_result.channel_index = m_axis_tdata[16];
                seen_result.rate_hz = m_axis_tdata[48:17];
                seen_result.channels = m_axis_tdata[50:49];
                seen_result.sample_bytes = m_axis_tdata[52:51];
                seen_result.frames = m_axis_tdata[84:53];
                seen_result.error_code = err_code_t'(m_axis_tdata[88:85]);
                seen_result.final_result = m_axis_tlast;
                board.match_result(seen_result);
            end
        end
    end

    function void put_le(logic [31:0] v, int width);
        for (int i = 0; i < width; i++)
            wav_bytes.push_back(v[8 * i +: 8]);
    endfunction

    function void fill_random(int n);
        for (int i = 0; i < n; i++)
            wav_bytes.push_back(8'($urandom));
    endfunction

    // assembles a wav image; a negative junk or other chunk length leaves that chunk out
    function void build_file(int chans, int bits, logic [31:0] rate, int junk_len,
                             int fmt_len, int other_len, int frames, int trail,
                             logic [15:0] comp);
        int pcm_len;
        pcm_len = frames * chans * ((bits == 8) ? 1 : 2);
        wav_bytes.delete();
        put_le(TAG_RIFF, 4);
        put_le($urandom, 4);
        put_le(TAG_WAVE, 4);
        if (junk_len >= 0)
        begin
            put_le(TAG_JUNK, 4);
            put_le(junk_len, 4);
            fill_random(junk_len + junk_len % 2);
        end
        put_le(TAG_FMT, 4);
        put_le(fmt_len, 4);
        put_le(comp, 2);
        put_le(chans, 2);
        put_le(rate, 4);
        put_le($urandom, 4);
        put_le($urandom, 2);
        put_le(bits, 2);
        if (fmt_len > 16)
            fill_random(fmt_len - 16 + fmt_len % 2);
        if (other_len >= 0)
        begin
            put_le(TAG_LIST, 4);
            other_size_at = wav_bytes.size();
            put_le(other_len, 4);
            fill_random(other_len + other_len % 2);
        end
        data_tag_at = wav_bytes.size();
        put_le(TAG_DATA, 4);
        put_le(pcm_len, 4);
        for (int i = 0; i < pcm_len; i++)
            wav_bytes.push_back(extreme_fill ? pcm_extremes[i % 4] : 8'($urandom));
        fill_random(trail);
    endfunction

    function void plain_file(int chans, int bits);
        build_file(chans, bits, 32'd22050, -1, 16, -1, 2, 0, FMT_PCM);
    endfunction

    // one byte on the slave stream, with sender bursts and gaps
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 30);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= eof;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // file length is only changed once the block has gone quiet
    task automatic write_length(input logic [31:0] v);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        board.file_len = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // streams the first count bytes, marking the last one as end of file
    task automatic play_file(input logic [31:0] length, input int count, input bit rewrite);
        if (rewrite)
            write_length(length);
        for (int i = 0; i < count; i++)
            send_byte(wav_bytes[i], i == count - 1);
    endtask

    task automatic play_whole(input logic [31:0] length);
        play_file(length, wav_bytes.size(), 1'b1);
    endtask

    initial
    begin
        #TIMEOUT_NS;
        $display("%0t ns: timeout, %0d results still owed", $time,
                 board.pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int          size;
        int          count;
        int          random_bytes;
        int          junk_len;
        int          other_len;
        logic [31:0] length;
        logic [31:0] rate;
        board.clear_all();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // well-formed files, sample extremes, padding and chunk variants
        extreme_fill = 1'b1;
        build_file(2, 16, 32'd44100, -1, 16, -1, 2, 0, FMT_PCM);
        play_whole(wav_bytes.size());
        build_file(1, 8, 32'hFFFF_FFFF, 3, 19, 5, 4, 2, FMT_PCM);
        play_whole(wav_bytes.size());
        build_file(2, 8, 32'd1, 0, 16, 0, 2, 0, FMT_PCM);
        play_whole(32'hFFFF_FFFF);
        extreme_fill = 1'b0;

        // file too small, including a zero length
        plain_file(1, 16);
        play_whole(32'd43);
        play_whole(32'd0);

        // broken riff tag, also with end of file on the failing byte
        plain_file(1, 16);
        wav_bytes[0] = 8'h00;
        play_whole(wav_bytes.size());
        play_file(wav_bytes.size(), 4, 1'b0);

        // broken wave tag
        plain_file(2, 8);
        wav_bytes[8] = wav_bytes[8] ^ 8'h20;
        play_whole(wav_bytes.size());

        // junk chunk running past the end of the file
        build_file(1, 8, 32'd8000, 4, 16, -1, 2, 0, FMT_PCM);
        wav_bytes[19] = 8'h40;
        play_whole(wav_bytes.size());

        // unknown first tag, then a wrong fmt tag after junk
        plain_file(1, 8);
        wav_bytes[12] = 8'h58;
        play_whole(wav_bytes.size());
        build_file(1, 8, 32'd8000, 2, 16, -1, 2, 0, FMT_PCM);
        wav_bytes[22] = 8'h46;
        play_whole(wav_bytes.size());

        // fmt chunk faults: size, compression, channels, rate, bits
        build_file(1, 16, 32'd8000, -1, 14, -1, 2, 0, FMT_PCM);
        play_whole(wav_bytes.size());
        build_file(1, 16, 32'd8000, -1, 16, -1, 2, 0, FMT_FLOAT);
        play_whole(wav_bytes.size());
        plain_file(3, 16);
        play_whole(wav_bytes.size());
        plain_file(0, 16);
        play_whole(wav_bytes.size());
        build_file(2, 16, 32'd0, -1, 16, -1, 2, 0, FMT_PCM);
        play_whole(wav_bytes.size());
        plain_file(1, 12);
        play_whole(wav_bytes.size());

        // header cut short by the declared length and by an early end
        plain_file(1, 16);
        play_whole(data_tag_at + 3);
        play_file(wav_bytes.size(), 20, 1'b1);

        // unknown chunk overrunning the file
        build_file(2, 16, 32'd16000, -1, 16, 4, 2, 0, FMT_PCM);
        wav_bytes[other_size_at + 3] = 8'h10;
        play_whole(wav_bytes.size());

        // data size faults: empty, not whole frames, past the file end
        build_file(2, 16, 32'd16000, -1, 16, -1, 0, 0, FMT_PCM);
        play_whole(wav_bytes.size());
        plain_file(2, 16);
        wav_bytes[data_tag_at + 4] = wav_bytes[data_tag_at + 4] ^ 8'h01;
        play_whole(wav_bytes.size());
        plain_file(1, 16);
        play_whole(wav_bytes.size() - 1);

        // end of file in the middle of the samples
        build_file(2, 16, 32'd48000, -1, 16, -1, 3, 0, FMT_PCM);
        play_file(wav_bytes.size(), wav_bytes.size() - 3, 1'b1);

        // random files, mostly well formed, some damaged, cut or noise
        random_bytes = 0;
        while (random_bytes < 250)
        begin
            case ($urandom_range(0, 9))
                0: rate = 32'd1;
                1: rate = 32'hFFFF_FFFF;
                default: rate = $urandom;
            endcase
            junk_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : -1;
            other_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : -1;
            build_file($urandom_range(1, 2), $urandom_range(0, 1) ? 16 : 8, rate, junk_len,
                       ($urandom_range(0, 2) == 0) ? $urandom_range(17, 20) : 16,
                       other_len, $urandom_range(1, 6),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, FMT_PCM);
            size = wav_bytes.size();
            length = size;
            count = size;
            case ($urandom_range(0, 19))
                0, 1: wav_bytes[$urandom_range(0, size - 1)] = 8'($urandom);
                2, 3: count = $urandom_range(1, size - 1);
                4, 5: length = size - $urandom_range(1, 8);
                6: length = size + $urandom_range(1, 8);
                7:
                begin
                    wav_bytes.delete();
                    fill_random($urandom_range(1, 40));
                    count = wav_bytes.size();
                    length = $urandom_range(0, 60);
                end
                default: ;
            endcase
            play_file(length, count, (length != board.file_len) || ($urandom_range(0, 3) == 0));
            random_bytes += count;
        end

        // drain, then allow for the pipeline
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d files in %0d bytes: %0d format items, %0d samples, %0d errors",
                 board.files_seen, board.bytes_seen, board.formats_seen, board.samples_seen,
                 board.errors_seen);
        $display("%0d of 13 error codes reached, file lengths from 0 to all ones",
                 $countones(board.codes_seen));
        if (board.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
